[rtl/kle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke line editor package
// Shared constants, key codes, types and the key classifier used by the
// line store cells and the controller.
// ----------------------------------------------------------------------------
package kle_pkg;

  // Number of character cells in the line store.
  localparam int LINE_CAPACITY = 64;
  // Character width and the width of a position from 0 to LINE_CAPACITY.
  localparam int CHAR_W = 8;
  localparam int POS_W  = $clog2(LINE_CAPACITY + 1);

  // Key codes.
  localparam logic [CHAR_W-1:0] KEY_UP_A    = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] KEY_UP_Z    = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] KEY_LO_A    = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] KEY_LO_Z    = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] KEY_DIG_0   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] KEY_DIG_9   = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] KEY_RIGHT   = 8'h3E;  // '>'
  localparam logic [CHAR_W-1:0] KEY_LEFT    = 8'h3C;  // '<'
  localparam logic [CHAR_W-1:0] KEY_HOME    = 8'h5B;  // '['
  localparam logic [CHAR_W-1:0] KEY_END     = 8'h5D;  // ']'

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } kle_state_t;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic             insert;  // write the key at the cursor, shift the tail right
    logic             shift;   // move every cell one place towards the head
    logic [POS_W-1:0] cursor;  // current insertion point
  } cell_ctrl_t;

  // True for letters and digits.
  function automatic logic is_alnum(input logic [CHAR_W-1:0] k);
    return ((k >= KEY_UP_A) && (k <= KEY_UP_Z)) ||
           ((k >= KEY_LO_A) && (k <= KEY_LO_Z)) ||
           ((k >= KEY_DIG_0) && (k <= KEY_DIG_9));
  endfunction

endpackage
`default_nettype wire

[rtl/keystroke_line_editor_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke line editor
// Rebuilds a line from a keystroke log in a row of character cells with a
// cursor, and emits the line one character per item on a flush.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_stall   key_code[7:0], flush
//   out_      output     out_valid/out_stall char[7:0], has_char, overflowed, last
//
// Inserts shift the cells beyond the cursor in the same cycle as the key is taken.
// A flush of n characters drains the row at one item per cycle while the
// output does not stall, and holds the input until the drain ends. An empty
// line loads its single item as the flush is taken and holds nothing.
// Synchronous active-low reset clears the count, cursor, flag and output valid.
// Keys are accepted while idle, also while an output item waits; a flush
// waits for a free output register.
// ----------------------------------------------------------------------------
module keystroke_line_editor_top
  import kle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] in_key_code,
  input  wire logic              in_flush,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAR_W-1:0] out_char,
  output logic                   out_has_char,
  output logic                   out_overflowed,
  output logic                   out_last
);

  cell_ctrl_t        ctrl;
  logic [CHAR_W-1:0] cell_q [LINE_CAPACITY];

  // Controller.
  kle_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_code    (in_key_code),
    .in_flush       (in_flush),
    .head_data      (cell_q[0]),
    .ctrl           (ctrl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_has_char   (out_has_char),
    .out_overflowed (out_overflowed),
    .out_last       (out_last)
  );

  // Row of character cells, each linked to both neighbours.
  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] left_d;
    logic [CHAR_W-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_body_l
      assign left_d = cell_q[i-1];
    end

    if (i == LINE_CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_body_r
      assign right_d = cell_q[i+1];
    end

    kle_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (POS_W'(i)),
      .key        (in_key_code),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i])
    );
  end

endmodule
`default_nettype wire

[rtl/kle_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke line editor cell
// One character of the line store. On an insert it takes the key when it sits
// at the cursor, or its left neighbour's character when it sits beyond it; on
// a drain step it takes its right neighbour's character.
// ----------------------------------------------------------------------------
module kle_cell
  import kle_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [POS_W-1:0]  cell_idx,
  input  wire logic [CHAR_W-1:0] key,
  input  wire logic [CHAR_W-1:0] left_data,
  input  wire logic [CHAR_W-1:0] right_data,
  output logic      [CHAR_W-1:0] data
);

  logic [CHAR_W-1:0] data_r;
  logic [CHAR_W-1:0] data_nxt;

  // Select the next character for this place.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = right_data;
    end else if (ctrl.insert) begin
      if (cell_idx == ctrl.cursor) begin
        data_nxt = key;
      end else if (cell_idx > ctrl.cursor) begin
        data_nxt = left_data;
      end
    end
  end

  // Character register; its contents are only read below the fill count.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

[rtl/kle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke line editor controller
// Keeps the fill count, cursor and overflow flag, decodes keys into cell
// controls, and drains the line through the output register on a flush.
// ----------------------------------------------------------------------------
module kle_ctrl
  import kle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] in_key_code,
  input  wire logic              in_flush,
  input  wire logic [CHAR_W-1:0] head_data,
  output cell_ctrl_t             ctrl,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAR_W-1:0] out_char,
  output logic                   out_has_char,
  output logic                   out_overflowed,
  output logic                   out_last
);

  kle_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  cursor_r, cursor_nxt;
  logic              flag_r, flag_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_has_char_r, out_has_char_nxt;
  logic              out_overflowed_r, out_overflowed_nxt;
  logic              out_last_r, out_last_nxt;

  logic accept;
  logic out_free;
  logic is_empty;
  logic empty_flush;
  logic do_insert;
  logic do_shift;
  logic load_out;

  // Handshake: keys pass while idle, a flush also waits for a free output register.
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != ST_IDLE) || (in_flush && !out_free);
  assign accept      = in_valid && !in_stall;
  assign is_empty    = (count_r == '0);
  assign empty_flush = accept && in_flush && is_empty;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_flush && !is_empty) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free && (count_r == POS_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Cell controls and output loading.
  always_comb begin
    do_insert = accept && !in_flush && is_alnum(in_key_code) &&
                (count_r < POS_W'(LINE_CAPACITY));
    do_shift  = (state_r == ST_DRAIN) && out_free;
    load_out  = do_shift || empty_flush;
    ctrl.insert = do_insert;
    ctrl.shift  = do_shift;
    ctrl.cursor = cursor_r;
  end

  // Count, cursor and overflow flag.
  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    flag_nxt   = flag_r;
    if (do_shift) begin
      count_nxt = count_r - POS_W'(1);
      if (count_r == POS_W'(1)) begin
        flag_nxt = 1'b0;
      end
    end else if (empty_flush) begin
      flag_nxt = 1'b0;
    end else if (accept && in_flush) begin
      cursor_nxt = '0;
    end else if (accept) begin
      if (is_alnum(in_key_code)) begin
        if (do_insert) begin
          count_nxt  = count_r + POS_W'(1);
          cursor_nxt = cursor_r + POS_W'(1);
        end else begin
          flag_nxt = 1'b1;
        end
      end else if (in_key_code == KEY_LEFT) begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - POS_W'(1);
        end
      end else if (in_key_code == KEY_RIGHT) begin
        if (cursor_r < count_r) begin
          cursor_nxt = cursor_r + POS_W'(1);
        end
      end else if (in_key_code == KEY_HOME) begin
        cursor_nxt = '0;
      end else if (in_key_code == KEY_END) begin
        cursor_nxt = count_r;
      end
    end
  end

  // Output item contents.
  always_comb begin
    out_char_nxt       = empty_flush ? '0 : head_data;
    out_has_char_nxt   = !empty_flush;
    out_overflowed_nxt = flag_r;
    out_last_nxt       = empty_flush || (count_r == POS_W'(1));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      flag_r   <= flag_nxt;
      if (out_free) begin
        out_valid_r <= load_out;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r       <= out_char_nxt;
      out_has_char_r   <= out_has_char_nxt;
      out_overflowed_r <= out_overflowed_nxt;
      out_last_r       <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_has_char   = out_has_char_r;
  assign out_overflowed = out_overflowed_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keystroke line editor testbench
// Sends keystroke items to keystroke_line_editor_top and checks every flushed
// character against a line predictor kept inside the testbench. The sender
// works in bursts with random gaps and the receiver stalls on its own changing
// pattern. A directed pass is followed by a full-line pass and random lines.
// ----------------------------------------------------------------------------
module tb;
  import kle_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int TOTAL_ITEMS   = 360;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  // One character of a flushed line, as the block presents it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has_char;
    logic              overflowed;
    logic              last;
  } line_char_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_key_code = '0;
  logic              in_flush = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_has_char;
  logic              out_overflowed;
  logic              out_last;

  // Predicted line store, cursor and drop flag.
  logic [CHAR_W-1:0] text_buf [LINE_CAPACITY];
  logic [POS_W-1:0]  text_len = '0;
  logic [POS_W-1:0]  caret = '0;
  logic              dropped_flag = 1'b0;
  line_char_t        expected_chars [$];

  int          mismatch_count = 0;
  int          items_sent = 0;
  int          lines_flushed = 0;
  int          overflow_lines = 0;
  int          chars_checked = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_phase = 0;
  stall_mode_t stall_mode = STALL_NONE;
  line_char_t  got_char;
  line_char_t  want_char;

  keystroke_line_editor_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_code    (in_key_code),
    .in_flush       (in_flush),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_has_char   (out_has_char),
    .out_overflowed (out_overflowed),
    .out_last       (out_last)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Letters and digits are the only keys that enter the line.
  function automatic logic is_text_key(input logic [CHAR_W-1:0] key);
    return (key >= KEY_UP_A && key <= KEY_UP_Z) ||
           (key >= KEY_LO_A && key <= KEY_LO_Z) ||
           (key >= KEY_DIG_0 && key <= KEY_DIG_9);
  endfunction

  function automatic logic [CHAR_W-1:0] random_text_key();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return CHAR_W'($urandom_range(KEY_UP_A, KEY_UP_Z));
    else if (pick == 1) return CHAR_W'($urandom_range(KEY_LO_A, KEY_LO_Z));
    else return CHAR_W'($urandom_range(KEY_DIG_0, KEY_DIG_9));
  endfunction

  // Applies one keystroke to the predicted line and queues the characters
  // that a flush releases.
  task automatic apply_keystroke(input logic [CHAR_W-1:0] key, input logic fl);
    line_char_t r;
    int i;
    if (fl) begin
      if (text_len == 0) begin
        r = {{CHAR_W{1'b0}}, 1'b0, dropped_flag, 1'b1};
        expected_chars = {expected_chars, r};
      end else begin
        for (i = 0; i < text_len; i++) begin
          r.ch = text_buf[i];
          r.has_char = 1'b1;
          r.overflowed = dropped_flag;
          r.last = (i == text_len - 1);
          expected_chars = {expected_chars, r};
        end
      end
      if (dropped_flag) overflow_lines++;
      lines_flushed++;
      text_len = '0;
      caret = '0;
      dropped_flag = 1'b0;
    end else if (is_text_key(key)) begin
      if (text_len == LINE_CAPACITY) begin
        dropped_flag = 1'b1;
      end else begin
        for (i = int'(text_len); i > int'(caret); i--) text_buf[i] = text_buf[i-1];
        text_buf[caret] = key;
        text_len = text_len + 1'b1;
        caret = caret + 1'b1;
      end
    end else if (key == KEY_LEFT) begin
      if (caret != 0) caret = caret - 1'b1;
    end else if (key == KEY_RIGHT) begin
      if (caret < text_len) caret = caret + 1'b1;
    end else if (key == KEY_HOME) begin
      caret = '0;
    end else if (key == KEY_END) begin
      caret = text_len;
    end
  endtask

  // Offers one item and waits for it to be taken. The expectation is formed
  // when the item is offered, which is always before its first result can
  // appear. Between bursts the sender idles for a random gap.
  task automatic send_item(input logic [CHAR_W-1:0] key, input logic fl);
    apply_keystroke(key, fl);
    in_valid <= 1'b1;
    in_key_code <= key;
    in_flush <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(60, 150);
      else burst_left = $urandom_range(0, 24);
    end
  endtask

  // Cursor moves at both ends, every key class and its boundaries, empty and
  // single-character lines, and a flush carrying a key that must be ignored.
  task automatic test_basic_editing();
    send_item('0, 1'b1);
    send_item(KEY_LEFT, 1'b0);
    send_item(KEY_RIGHT, 1'b0);
    send_item(KEY_UP_A, 1'b0);
    send_item(KEY_LO_Z, 1'b0);
    send_item(KEY_LEFT, 1'b0);
    send_item(KEY_DIG_0, 1'b0);
    send_item(KEY_HOME, 1'b0);
    send_item(KEY_DIG_9, 1'b0);
    send_item(KEY_END, 1'b0);
    send_item(KEY_UP_Z, 1'b0);
    send_item(KEY_RIGHT, 1'b0);
    send_item(KEY_LO_A, 1'b0);
    send_item(KEY_UP_A - 8'd1, 1'b0);
    send_item(KEY_HOME + 8'd1, 1'b0);
    send_item('1, 1'b0);
    send_item('0, 1'b0);
    send_item(KEY_DIG_0 - 8'd1, 1'b0);
    send_item(KEY_DIG_9 + 8'd1, 1'b0);
    send_item(KEY_LO_A - 8'd1, 1'b0);
    send_item(KEY_LO_Z + 8'd1, 1'b0);
    send_item(KEY_UP_A, 1'b1);
    send_item('1, 1'b1);
    send_item(KEY_LO_Z, 1'b0);
    send_item('0, 1'b1);
  endtask

  // Fills the store with the cursor in the middle, drops inserts at several
  // cursor positions, then checks that the flag clears and a line of exactly
  // full size flushes without it.
  task automatic test_full_line();
    int i;
    for (i = 0; i < LINE_CAPACITY / 2; i++) send_item(random_text_key(), 1'b0);
    send_item(KEY_HOME, 1'b0);
    for (i = 0; i < LINE_CAPACITY / 2; i++) send_item(random_text_key(), 1'b0);
    send_item(KEY_LEFT, 1'b0);
    for (i = 0; i < 3; i++) send_item(random_text_key(), 1'b0);
    send_item(KEY_RIGHT, 1'b0);
    send_item(random_text_key(), 1'b0);
    send_item(KEY_END, 1'b0);
    send_item(random_text_key(), 1'b0);
    send_item('0, 1'b1);
    send_item('0, 1'b1);
    for (i = 0; i < LINE_CAPACITY; i++) send_item(random_text_key(), 1'b0);
    send_item('1, 1'b1);
  endtask

  // Random lines: mostly edits with random content, some noise bytes, and
  // a flush at the end of each. Most lines are short, a few near capacity.
  // The pass stops once the whole run has sent its share of items.
  task automatic test_random_lines();
    int target;
    int inserted;
    int pick;
    logic [CHAR_W-1:0] key;
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 4) == 0) target = $urandom_range(50, 70);
      else target = $urandom_range(0, 12);
      inserted = 0;
      while (inserted < target && items_sent < TOTAL_ITEMS - 1) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          key = random_text_key();
          inserted++;
        end else if (pick < 65) key = KEY_LEFT;
        else if (pick < 72) key = KEY_RIGHT;
        else if (pick < 77) key = KEY_HOME;
        else if (pick < 82) key = KEY_END;
        else key = CHAR_W'($urandom_range(0, 255));
        send_item(key, 1'b0);
      end
      send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Checks each accepted character and drives the receiver's stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_char = {out_char, out_has_char, out_overflowed, out_last};
      chars_checked++;
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected character: char=%h has=%b ovf=%b last=%b",
                   $realtime, got_char.ch, got_char.has_char,
                   got_char.overflowed, got_char.last);
      end else begin
        want_char = expected_chars.pop_front();
        if (got_char.ch !== want_char.ch || got_char.has_char !== want_char.has_char ||
            got_char.overflowed !== want_char.overflowed ||
            got_char.last !== want_char.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"[%0t] mismatch: expected char=%h has=%b ovf=%b last=%b,",
                      " got char=%h has=%b ovf=%b last=%b"},
                     $realtime, want_char.ch, want_char.has_char, want_char.overflowed,
                     want_char.last, got_char.ch, got_char.has_char,
                     got_char.overflowed, got_char.last);
        end
      end
    end

    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (stall_phase % 4 == 0);
      default:        out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
    $display("keystroke_line_editor_top verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_editing();
    test_full_line();
    test_random_lines();

    // Drain whatever is still in flight.
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += expected_chars.size();

    $display("Run covered %0d keystroke items and %0d flushed lines, %0d with dropped inserts.",
             items_sent, lines_flushed, overflow_lines);
    $display("%0d characters checked, %0d mismatches.", chars_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("keystroke_line_editor_top verification clean");
    else
      $display("keystroke_line_editor_top verification failed");
    $finish;
  end

endmodule

[keystroke_line_editor_top.f]
rtl/kle_pkg.sv
rtl/kle_cell.sv
rtl/kle_ctrl.sv
rtl/keystroke_line_editor_top.sv
sim/tb.sv
